// ===== design/pimh_pkg.sv =====
package pimh_pkg;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [1:0] HIST_DA = 2'd0;
	localparam logic [1:0] HIST_PA = 2'd1;
	localparam logic [1:0] HIST_AA = 2'd2;
	localparam logic [1:0] HIST_NONE = 2'd3;

	// species code: charge in the top three bits, mass number below
	localparam logic [6:0] SP_PROTON   = 7'h11;
	localparam logic [6:0] SP_DEUTERON = 7'h12;
	localparam logic [6:0] SP_ALPHA    = 7'h24;

	// thresholds and low edge in 1/4096 MeV
	localparam int U_W = 30;
	localparam logic signed [U_W-1:0] THR_DA = 30'sd22950099;
	localparam logic signed [U_W-1:0] THR_PA = 30'sd19124836;
	localparam logic signed [U_W-1:0] THR_AA = 30'sd30543440;
	localparam logic signed [U_W-1:0] LOW_EDGE = 30'sd20480;
	localparam logic signed [U_W-1:0] SPAN = 30'sd122880;
	localparam int SPAN_SHIFT = 13;          // span = 2^13 * 15
	localparam logic [12:0] RECIP15 = 13'd4369;  // floor(2^16 / 15)

	localparam int ACC_W  = 46;
	localparam int RAD_W  = 56;
	localparam int ROOT_W = 28;

	typedef struct packed {
		logic               op;
		logic               new_event;
		logic signed [18:0] px;
		logic signed [18:0] py;
		logic signed [18:0] pz;
		logic [20:0]        e;
		logic [19:0]        m;
		logic [6:0]         sp;
		logic [1:0]         hsel;
		logic [8:0]         bin;
	} item_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_START, ST_SCAN, ST_LOAD, ST_CHECK, ST_MUL, ST_SQ0,
		ST_SQRT, ST_BIN1, ST_BIN2, ST_BIN3, ST_RD, ST_WR, ST_NEXT, ST_STORE,
		ST_RQ, ST_RDOUT, ST_DONE
	} back_state_t;

endpackage

// ===== design/pimh_front.sv =====
module pimh_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic                   operation,
	input  logic                   new_event,
	input  logic signed [18:0]     momentum_x,
	input  logic signed [18:0]     momentum_y,
	input  logic signed [18:0]     momentum_z,
	input  logic [17:0]            kinetic_energy,
	input  logic [19:0]            rest_mass,
	input  logic [2:0]             charge,
	input  logic [3:0]             mass_number,
	input  logic [1:0]             histogram_select,
	input  logic [8:0]             bin_index,
	input  pimh_pkg::back_status_t bstat,
	input  logic                   q_pop,
	output logic                   q_valid,
	output pimh_pkg::item_t        q_item
);

	pimh_pkg::item_t fifo_q [2];
	pimh_pkg::item_t item_in;
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      fill_q;
	logic            accept;

	always_comb begin
		item_in.op        = operation;
		item_in.new_event = new_event;
		item_in.px        = momentum_x;
		item_in.py        = momentum_y;
		item_in.pz        = momentum_z;
		item_in.e         = {1'b0, rest_mass} + {3'b000, kinetic_energy};
		item_in.m         = rest_mass;
		item_in.sp        = {charge, mass_number};
		item_in.hsel      = histogram_select;
		item_in.bin       = bin_index;
	end

	// hold off while the queue is full or the histograms are being cleared
	assign item_stall = (fill_q == 2'd2) || bstat.clearing;
	assign accept     = item_valid && !item_stall;
	assign q_valid    = (fill_q != 2'd0);
	assign q_item     = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (accept) fifo_q[wr_ptr_q] <= item_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (accept) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + 2'(accept) - 2'(q_pop);
		end
	end

endmodule

// ===== design/pimh_isqrt.sv =====
module pimh_isqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [pimh_pkg::RAD_W-1:0]      radicand,
	output logic                            done,
	output logic [pimh_pkg::ROOT_W-1:0]     root
);

	localparam int RW = pimh_pkg::ROOT_W;
	localparam int CW = $clog2(RW + 1);

	logic [pimh_pkg::RAD_W-1:0] rad_q;
	logic [RW+1:0]              rem_q;
	logic [RW-1:0]              root_q;
	logic [CW-1:0]              left_q;
	logic                       busy_q;
	logic [RW+1:0]              rem_n, trial;

	// one root bit per cycle, two radicand bits shifted in
	assign rem_n = {rem_q[RW-1:0], rad_q[pimh_pkg::RAD_W-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign root  = root_q;
	assign done  = busy_q && (left_q == CW'(1));

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[pimh_pkg::RAD_W-3:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			left_q <= CW'(RW);
		end else if (busy_q) begin
			left_q <= left_q - CW'(1);
			if (left_q == CW'(1)) busy_q <= 1'b0;
		end
	end

endmodule

// ===== design/pimh_back.sv =====
module pimh_back #(
	parameter int MAX_PARTICLES = 16,
	parameter int NUM_BINS      = 300,
	parameter int COUNT_WIDTH   = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  pimh_pkg::item_t        q_item,
	output logic                   q_pop,
	output pimh_pkg::back_status_t bstat,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [31:0]            bin_count,
	output logic [3:0]             pairs_filled,
	output logic                   store_full
);

	localparam int KW   = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CNTW = $clog2(MAX_PARTICLES + 1);
	localparam int NB2  = NUM_BINS + 2;
	localparam int IW   = $clog2(NB2);
	localparam int NBW  = $clog2(NUM_BINS + 1);
	localparam int BPW  = 17 + NBW;
	localparam int VW   = BPW - pimh_pkg::SPAN_SHIFT;
	localparam int QW   = VW - 3;
	localparam int AW   = pimh_pkg::ACC_W;

	typedef struct packed {
		logic signed [18:0] px;
		logic signed [18:0] py;
		logic signed [18:0] pz;
		logic [20:0]        e;
		logic [19:0]        m;
		logic [6:0]         sp;
	} entry_t;

	pimh_pkg::back_state_t state_q, state_n;

	entry_t                 store_q [MAX_PARTICLES];
	entry_t                 ent_q;
	logic [COUNT_WIDTH-1:0] hist_q [3][NB2];
	logic [COUNT_WIDTH-1:0] rdata_q [3];

	pimh_pkg::item_t        cur_q;
	logic [CNTW-1:0]        cnt_q;
	logic [KW-1:0]          k_q;
	logic [3:0]             fills_q;
	logic                   full_q;
	logic [31:0]            res_q;
	logic [IW-1:0]          clr_q;
	logic [1:0]             hsel_q;
	logic [2:0]             mstep_q;
	logic signed [43:0]     prod_s1;
	logic signed [AW-1:0]   acc_q;
	logic                   under_q, over_q;
	logic [BPW-1:0]         bprod_s1;
	logic [VW-1:0]          v_s1;
	logic [VW+12:0]         rp_s1;
	logic [IW-1:0]          idx_q;
	logic                   out_valid_q;
	logic [31:0]            out_count_q;
	logic [3:0]             out_fills_q;
	logic                   out_full_q;

	logic                   sq_start, sq_done;
	logic [pimh_pkg::ROOT_W-1:0] sq_root;
	logic [IW-1:0]          mem_addr;
	logic                   out_load;
	logic [1:0]             pair_hist;
	logic signed [21:0]     op_a, op_b;
	logic signed [AW-1:0]   term;
	logic signed [pimh_pkg::U_W-1:0] u, thr;
	logic [VW-1:0]          v_n, r_n;
	logic [QW-1:0]          q0, q_n;
	logic [COUNT_WIDTH-1:0] hit_cnt;
	logic                   read_ok;

	function automatic logic [COUNT_WIDTH-1:0] hit_cnt_read(input logic [1:0] sel);
		case (sel)
			pimh_pkg::HIST_DA: hit_cnt_read = rdata_q[0];
			pimh_pkg::HIST_PA: hit_cnt_read = rdata_q[1];
			default:           hit_cnt_read = rdata_q[2];
		endcase
	endfunction

	pimh_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand ({acc_q[43:0], 12'h000}),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign bstat.clearing = (state_q == pimh_pkg::ST_CLEAR);
	assign result_valid   = out_valid_q;
	assign bin_count      = out_count_q;
	assign pairs_filled   = out_fills_q;
	assign store_full     = out_full_q;

	// pair classification against the loaded store entry
	always_comb begin
		if ((cur_q.sp == pimh_pkg::SP_DEUTERON && ent_q.sp == pimh_pkg::SP_ALPHA) ||
		    (ent_q.sp == pimh_pkg::SP_DEUTERON && cur_q.sp == pimh_pkg::SP_ALPHA))
			pair_hist = pimh_pkg::HIST_DA;
		else if ((cur_q.sp == pimh_pkg::SP_PROTON && ent_q.sp == pimh_pkg::SP_ALPHA) ||
		         (ent_q.sp == pimh_pkg::SP_PROTON && cur_q.sp == pimh_pkg::SP_ALPHA))
			pair_hist = pimh_pkg::HIST_PA;
		else if (cur_q.sp == pimh_pkg::SP_ALPHA && ent_q.sp == pimh_pkg::SP_ALPHA)
			pair_hist = pimh_pkg::HIST_AA;
		else
			pair_hist = pimh_pkg::HIST_NONE;
	end

	// shared multiplier operands: m*m, mo*mo, e*E, then the three momentum products
	always_comb begin
		case (mstep_q)
			3'd0: begin op_a = 22'({2'b00, cur_q.m}); op_b = 22'({2'b00, cur_q.m}); end
			3'd1: begin op_a = 22'({2'b00, ent_q.m}); op_b = 22'({2'b00, ent_q.m}); end
			3'd2: begin op_a = 22'({1'b0, cur_q.e}); op_b = 22'({1'b0, ent_q.e}); end
			3'd3: begin op_a = 22'(cur_q.px); op_b = 22'(ent_q.px); end
			3'd4: begin op_a = 22'(cur_q.py); op_b = 22'(ent_q.py); end
			3'd5: begin op_a = 22'(cur_q.pz); op_b = 22'(ent_q.pz); end
			default: begin op_a = '0; op_b = '0; end
		endcase
		case (mstep_q)
			3'd1, 3'd2: term = AW'(prod_s1);
			3'd3: term = AW'(prod_s1) <<< 1;
			3'd4, 3'd5, 3'd6: term = -(AW'(prod_s1) <<< 1);
			default: term = '0;
		endcase
	end

	always_comb begin
		case (hsel_q)
			pimh_pkg::HIST_DA: thr = pimh_pkg::THR_DA;
			pimh_pkg::HIST_PA: thr = pimh_pkg::THR_PA;
			default:           thr = pimh_pkg::THR_AA;
		endcase
		u    = $signed({2'b00, sq_root}) - thr + pimh_pkg::LOW_EDGE;
		v_n  = bprod_s1[BPW-1:pimh_pkg::SPAN_SHIFT];
		q0   = rp_s1[VW+12:16];
		r_n  = v_s1 - VW'(q0) * VW'(15);
		q_n  = q0 + QW'(r_n >= VW'(15));
		case (hsel_q)
			pimh_pkg::HIST_DA: hit_cnt = rdata_q[0];
			pimh_pkg::HIST_PA: hit_cnt = rdata_q[1];
			default:           hit_cnt = rdata_q[2];
		endcase
		read_ok = (int'(cur_q.bin) <= NUM_BINS + 1) && (cur_q.hsel != pimh_pkg::HIST_NONE);
	end

	// next state and handshake outputs
	always_comb begin
		state_n  = state_q;
		q_pop    = 1'b0;
		sq_start = 1'b0;
		out_load = 1'b0;
		mem_addr = (state_q == pimh_pkg::ST_RQ) ? IW'(cur_q.bin) : idx_q;
		case (state_q)
			pimh_pkg::ST_CLEAR: if (clr_q == IW'(NB2 - 1)) state_n = pimh_pkg::ST_IDLE;
			pimh_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_n = (q_item.op == pimh_pkg::OP_READ) ? pimh_pkg::ST_RQ
					                                           : pimh_pkg::ST_START;
				end
			end
			pimh_pkg::ST_START:
				state_n = (cnt_q == CNTW'(MAX_PARTICLES)) ? pimh_pkg::ST_DONE
				                                          : pimh_pkg::ST_SCAN;
			pimh_pkg::ST_SCAN:
				state_n = (CNTW'(k_q) == cnt_q) ? pimh_pkg::ST_STORE : pimh_pkg::ST_LOAD;
			pimh_pkg::ST_LOAD: state_n = pimh_pkg::ST_CHECK;
			pimh_pkg::ST_CHECK:
				state_n = (pair_hist == pimh_pkg::HIST_NONE) ? pimh_pkg::ST_NEXT
				                                             : pimh_pkg::ST_MUL;
			pimh_pkg::ST_MUL: if (mstep_q == 3'd6) state_n = pimh_pkg::ST_SQ0;
			pimh_pkg::ST_SQ0: begin
				if (acc_q < 0) state_n = pimh_pkg::ST_RD;
				else begin
					sq_start = 1'b1;
					state_n  = pimh_pkg::ST_SQRT;
				end
			end
			pimh_pkg::ST_SQRT: if (sq_done) state_n = pimh_pkg::ST_BIN1;
			pimh_pkg::ST_BIN1: state_n = pimh_pkg::ST_BIN2;
			pimh_pkg::ST_BIN2: state_n = pimh_pkg::ST_BIN3;
			pimh_pkg::ST_BIN3: state_n = pimh_pkg::ST_RD;
			pimh_pkg::ST_RD:   state_n = pimh_pkg::ST_WR;
			pimh_pkg::ST_WR:   state_n = pimh_pkg::ST_NEXT;
			pimh_pkg::ST_NEXT: state_n = pimh_pkg::ST_SCAN;
			pimh_pkg::ST_STORE: state_n = pimh_pkg::ST_DONE;
			pimh_pkg::ST_RQ:   state_n = pimh_pkg::ST_RDOUT;
			pimh_pkg::ST_RDOUT: state_n = pimh_pkg::ST_DONE;
			pimh_pkg::ST_DONE: begin
				if (!out_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_n  = pimh_pkg::ST_IDLE;
				end
			end
			default: state_n = pimh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pimh_pkg::ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == pimh_pkg::ST_CLEAR) clr_q <= clr_q + IW'(1);
			if (q_pop && q_item.op == pimh_pkg::OP_ADD && q_item.new_event) cnt_q <= '0;
			if (state_q == pimh_pkg::ST_STORE) cnt_q <= cnt_q + CNTW'(1);
			if (out_load) out_valid_q <= 1'b1;
			else if (!result_stall) out_valid_q <= 1'b0;
		end
	end

	// histogram memories: one registered read port, one write port each
	always_ff @(posedge clk) begin
		for (int h = 0; h < 3; h++) begin
			rdata_q[h] <= hist_q[h][mem_addr];
			if (state_q == pimh_pkg::ST_CLEAR)
				hist_q[h][clr_q] <= '0;
			else if (state_q == pimh_pkg::ST_WR && hsel_q == 2'(h))
				hist_q[h][idx_q] <= (hit_cnt == '1) ? hit_cnt : hit_cnt + COUNT_WIDTH'(1);
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= store_q[k_q];
		if (state_q == pimh_pkg::ST_STORE)
			store_q[cnt_q[KW-1:0]] <= '{px: cur_q.px, py: cur_q.py, pz: cur_q.pz,
			                            e: cur_q.e, m: cur_q.m, sp: cur_q.sp};
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			pimh_pkg::ST_IDLE: begin
				cur_q   <= q_item;
				k_q     <= '0;
				fills_q <= 4'd0;
				full_q  <= 1'b0;
				res_q   <= 32'd0;
			end
			pimh_pkg::ST_START: if (cnt_q == CNTW'(MAX_PARTICLES)) full_q <= 1'b1;
			pimh_pkg::ST_CHECK: begin
				hsel_q  <= pair_hist;
				mstep_q <= 3'd0;
				acc_q   <= '0;
			end
			pimh_pkg::ST_MUL: begin
				prod_s1 <= op_a * op_b;
				acc_q   <= acc_q + term;
				mstep_q <= mstep_q + 3'd1;
			end
			pimh_pkg::ST_SQ0: if (acc_q < 0) idx_q <= '0;
			pimh_pkg::ST_BIN1: begin
				under_q  <= (u < 0);
				over_q   <= (u >= pimh_pkg::SPAN);
				bprod_s1 <= BPW'(u[16:0]) * BPW'(NUM_BINS);
			end
			pimh_pkg::ST_BIN2: begin
				v_s1  <= v_n;
				rp_s1 <= v_n * pimh_pkg::RECIP15;
			end
			pimh_pkg::ST_BIN3: begin
				if (under_q) idx_q <= '0;
				else if (over_q) idx_q <= IW'(NUM_BINS + 1);
				else idx_q <= IW'(q_n) + IW'(1);
			end
			pimh_pkg::ST_WR: if (fills_q != 4'd15) fills_q <= fills_q + 4'd1;
			pimh_pkg::ST_NEXT: k_q <= k_q + KW'(1);
			pimh_pkg::ST_RDOUT: res_q <= read_ok ? 32'(hit_cnt_read(cur_q.hsel)) : 32'd0;
			pimh_pkg::ST_DONE: begin
				if (out_load) begin
					out_count_q <= res_q;
					out_fills_q <= fills_q;
					out_full_q  <= full_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== design/pair_invariant_mass_histogrammer.sv =====
// An add compares the new item with each stored particle. A pair that is not counted is
// skipped, one whose squared mass is negative goes to the underflow bin, and any other takes
// 7 multiply steps, 28 square-root steps, 3 binning steps and a histogram read-modify-write.
// With the store full an add goes straight to its result; a read looks up one bin.
// One item is worked at a time; a two-entry queue lets the input run ahead. Reset is
// asynchronous, active low; a clearing pass then zeroes all NUM_BINS+2 bins of each histogram.
module pair_invariant_mass_histogrammer #(
	parameter int MAX_PARTICLES = 16,
	parameter int NUM_BINS      = 300,
	parameter int COUNT_WIDTH   = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               operation,
	input  logic               new_event,
	input  logic signed [18:0] momentum_x,
	input  logic signed [18:0] momentum_y,
	input  logic signed [18:0] momentum_z,
	input  logic [17:0]        kinetic_energy,
	input  logic [19:0]        rest_mass,
	input  logic [2:0]         charge,
	input  logic [3:0]         mass_number,
	input  logic [1:0]         histogram_select,
	input  logic [8:0]         bin_index,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [31:0]        bin_count,
	output logic [3:0]         pairs_filled,
	output logic               store_full
);

	pimh_pkg::back_status_t bstat;
	pimh_pkg::item_t        q_item;
	logic                   q_valid, q_pop;

	pimh_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.operation        (operation),
		.new_event        (new_event),
		.momentum_x       (momentum_x),
		.momentum_y       (momentum_y),
		.momentum_z       (momentum_z),
		.kinetic_energy   (kinetic_energy),
		.rest_mass        (rest_mass),
		.charge           (charge),
		.mass_number      (mass_number),
		.histogram_select (histogram_select),
		.bin_index        (bin_index),
		.bstat            (bstat),
		.q_pop            (q_pop),
		.q_valid          (q_valid),
		.q_item           (q_item)
	);

	pimh_back #(
		.MAX_PARTICLES (MAX_PARTICLES),
		.NUM_BINS      (NUM_BINS),
		.COUNT_WIDTH   (COUNT_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.bstat        (bstat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.bin_count    (bin_count),
		.pairs_filled (pairs_filled),
		.store_full   (store_full)
	);

endmodule
